### rtl/tcw_pkg.sv
// ============================================================================
// tcw_pkg
// Shared types and constants for the text console writer: input mode codes,
// special character codes, the blank cell value, the attribute reset value
// and the result item layout.
package tcw_pkg;

    // Input mode codes.
    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Control characters handled by a put.
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;

    // Blank cell used by clear and scroll: a space with attribute 0x0F.
    localparam logic [15:0] BLANK_CELL = 16'h0F20;

    // Reset value of the text attribute register.
    localparam logic [7:0] ATTR_RESET = 8'h0F;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [15:0] cell_value;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_line;
        logic        did_scroll;
    } result_t;

endpackage

### rtl/text_console_writer_unit.sv
// ============================================================================
// text_console_writer_unit
// Text-mode console with a frame buffer of ROWS x COLUMNS character cells.
// ============================================================================
// Each item is a put, a clear, a cell read or an unused mode code and returns
// one result item with the read cell, the cursor after the item and a scroll
// flag. A put of a plain character, newline or backspace goes on to its
// result through the finish state, and an on-screen cell read first waits in
// a read state for the registered read of the frame buffer. A put that runs
// past the last row scrolls through the frame buffer one cell per cycle over
// its single write port, then blanks the last row; a clear blanks the whole
// frame buffer. After reset the block blanks the whole frame buffer and holds
// off items meanwhile; the attribute register can be written at any time.
module text_console_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // Input item channel.
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  char_code,
    input  logic [4:0]  read_row,
    input  logic [6:0]  read_col,
    // Result item channel.
    output logic        result_valid,
    input  logic        result_stall,
    output logic [15:0] cell_value,
    output logic [6:0]  cursor_column,
    output logic [4:0]  cursor_line,
    output logic        did_scroll
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [7:0]        text_attribute_reg, text_attribute_next;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [15:0]       mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [15:0]       mem_rd_data;
    tcw_pkg::result_t  result;

    // Attribute register, written through the configuration channel.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        text_attribute_next = text_attribute_reg;
        if (cfg_valid && cfg_ready)
        begin
            text_attribute_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attribute_reg <= tcw_pkg::ATTR_RESET;
        end
        else
        begin
            text_attribute_reg <= text_attribute_next;
        end
    end

    // Control sequencer.
    tcw_sequencer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_sequencer (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .mode           (mode),
        .char_code      (char_code),
        .read_row       (read_row),
        .read_col       (read_col),
        .text_attribute (text_attribute_reg),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result)
    );

    // Frame buffer.
    tcw_frame_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_frame_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Result item fields.
    assign cell_value    = result.cell_value;
    assign cursor_column = result.cursor_column;
    assign cursor_line   = result.cursor_line;
    assign did_scroll    = result.did_scroll;

endmodule

### rtl/tcw_frame_mem.sv
// ============================================================================
// tcw_frame_mem
// Frame buffer of character cells: one write port and one read port, with a
// registered read whose data appears in the cycle after the address.
// ============================================================================
module tcw_frame_mem #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [15:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [15:0]       rd_data
);

    logic [15:0] frame_mem [DEPTH];
    logic [15:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/tcw_sequencer.sv
// ============================================================================
// tcw_sequencer
// Control sequencer of the console: keeps the cursor, decodes each item,
// drives the frame buffer ports for cell writes, cell reads, the scroll copy
// sweep and the blanking sweep, and holds the result item for the consumer.
// ============================================================================
module tcw_sequencer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int ADDR_W  = 11
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Input item channel.
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [1:0]           mode,
    input  logic [7:0]           char_code,
    input  logic [4:0]           read_row,
    input  logic [6:0]           read_col,
    // Configuration.
    input  logic [7:0]           text_attribute,
    // Frame buffer ports.
    output logic                 mem_wr_en,
    output logic [ADDR_W-1:0]    mem_wr_addr,
    output logic [15:0]          mem_wr_data,
    output logic                 mem_rd_en,
    output logic [ADDR_W-1:0]    mem_rd_addr,
    input  logic [15:0]          mem_rd_data,
    // Result item channel.
    output logic                 result_valid,
    input  logic                 result_stall,
    output tcw_pkg::result_t     result
);

    localparam int CELLS    = ROWS * COLUMNS;
    localparam int MOVE_CNT = CELLS - COLUMNS;
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int LINE_W   = $clog2(ROWS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_WAIT,
        S_SCROLL,
        S_BLANK,
        S_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [LINE_W-1:0]    line_reg, line_next;
    logic [ADDR_W-1:0]    cnt_reg, cnt_next;
    logic                 report_reg, report_next;
    logic                 scroll_reg, scroll_next;
    logic [15:0]          cell_reg, cell_next;
    logic                 result_valid_reg, result_valid_next;
    tcw_pkg::result_t     result_reg, result_next;

    // Cursor arithmetic for a put.
    logic [COL_W:0]       col_inc;
    logic [LINE_W:0]      line_inc;
    logic [COL_W-1:0]     put_col;
    logic [LINE_W:0]      put_line;
    logic                 put_write;
    logic                 put_overflow;
    logic                 read_in_range;

    always_comb
    begin
        col_inc   = {1'b0, col_reg} + 1'b1;
        line_inc  = {1'b0, line_reg} + 1'b1;
        put_write = 1'b0;
        if (char_code == tcw_pkg::CH_NEWLINE)
        begin
            put_col  = '0;
            put_line = line_inc;
        end
        else if (char_code == tcw_pkg::CH_BACKSPACE)
        begin
            put_col  = (col_reg == '0) ? col_reg : col_reg - 1'b1;
            put_line = {1'b0, line_reg};
        end
        else
        begin
            put_write = 1'b1;
            if (32'(col_inc) >= COLUMNS)
            begin
                put_col  = '0;
                put_line = line_inc;
            end
            else
            begin
                put_col  = col_inc[COL_W-1:0];
                put_line = {1'b0, line_reg};
            end
        end
        put_overflow  = (32'(put_line) >= ROWS);
        read_in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);
    end

    // Next state, cursor and memory control.
    always_comb
    begin
        state_next        = state_reg;
        col_next          = col_reg;
        line_next         = line_reg;
        cnt_next          = cnt_reg;
        report_next       = report_reg;
        scroll_next       = scroll_reg;
        cell_next         = cell_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        mem_wr_en         = 1'b0;
        mem_wr_addr       = cnt_reg;
        mem_wr_data       = tcw_pkg::BLANK_CELL;
        mem_rd_en         = 1'b0;
        mem_rd_addr       = cnt_reg;

        // The consumer takes the pending result item.
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cell_next   = '0;
                    scroll_next = 1'b0;
                    report_next = 1'b1;
                    state_next  = S_FINISH;
                    case (mode)
                        tcw_pkg::MODE_PUT:
                        begin
                            mem_wr_en   = put_write;
                            mem_wr_addr = ADDR_W'(line_reg * COLUMNS + col_reg);
                            mem_wr_data = {text_attribute, char_code};
                            col_next    = put_col;
                            if (put_overflow)
                            begin
                                line_next   = LINE_W'(ROWS - 1);
                                scroll_next = 1'b1;
                                cnt_next    = '0;
                                state_next  = S_SCROLL;
                            end
                            else
                            begin
                                line_next = put_line[LINE_W-1:0];
                            end
                        end
                        tcw_pkg::MODE_CLEAR:
                        begin
                            col_next   = '0;
                            line_next  = '0;
                            cnt_next   = '0;
                            state_next = S_BLANK;
                        end
                        tcw_pkg::MODE_READ:
                        begin
                            if (read_in_range)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = ADDR_W'(read_row * COLUMNS + read_col);
                                state_next  = S_READ_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_READ_WAIT:
            begin
                cell_next  = mem_rd_data;
                state_next = S_FINISH;
            end

            // Copy each cell one row up: read a row below, write the cell
            // read in the previous cycle.
            S_SCROLL:
            begin
                if (cnt_reg != ADDR_W'(MOVE_CNT))
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ADDR_W'(cnt_reg + COLUMNS);
                end
                if (cnt_reg != '0)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = cnt_reg - 1'b1;
                    mem_wr_data = mem_rd_data;
                end
                if (cnt_reg == ADDR_W'(MOVE_CNT))
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Fill cells from the counter up to the end with blanks.
            S_BLANK:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cnt_reg;
                mem_wr_data = tcw_pkg::BLANK_CELL;
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = report_reg ? S_FINISH : S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.cell_value    = cell_reg;
                    result_next.cursor_column = 7'(col_reg);
                    result_next.cursor_line   = 5'(line_reg);
                    result_next.did_scroll    = scroll_reg;
                    result_valid_next         = 1'b1;
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs. Reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_BLANK;
            col_reg          <= '0;
            line_reg         <= '0;
            cnt_reg          <= '0;
            report_reg       <= 1'b0;
            scroll_reg       <= 1'b0;
            cell_reg         <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            col_reg          <= col_next;
            line_reg         <= line_next;
            cnt_reg          <= cnt_next;
            report_reg       <= report_next;
            scroll_reg       <= scroll_next;
            cell_reg         <= cell_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/tcw_checker.sv
// ============================================================================
// tcw_checker
// Port-level checks of the text console writer, attached to the top level.
// ============================================================================
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [15:0] cell_value,
    input logic [6:0]  cursor_column,
    input logic [4:0]  cursor_line,
    input logic        did_scroll
);

    // A stalled result item holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(cell_value) && $stable(cursor_column)
            && $stable(cursor_line) && $stable(did_scroll))
    else $error("stalled result item changed");

    // The block works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
    else $error("item accepted while the previous one is at work");

    // A scroll leaves the cursor at the start of the last row.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && did_scroll |->
            cursor_column == 7'd0 && cursor_line == 5'(ROWS - 1))
    else $error("scroll left the cursor off the start of the last row");

    // The reported cursor stays on the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> 32'(cursor_column) < COLUMNS)
    else $error("cursor column beyond the right edge");

endmodule

bind text_console_writer_unit tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .cell_value    (cell_value),
    .cursor_column (cursor_column),
    .cursor_line   (cursor_line),
    .did_scroll    (did_scroll)
);

### tb/sv/text_console_writer_unit_tb.sv
// ============================================================================
// text_console_writer_unit_tb
// Self-checking testbench for the text console writer. A directed table of
// items runs first, followed by random phases under several attribute
// settings. Every accepted item is run through a behavioral console model
// that keeps its own frame buffer and cursor, and every result item is
// compared field by field against the oldest expected result.
// ============================================================================
module text_console_writer_unit_tb;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_AT     = 250;
    localparam int HOLD_CYCLES = 120;
    // Worst case: every item scrolls, every side idles at its longest.
    localparam longint LIMIT_TIME = 64_000_000;

    // Mode code that the block does not use.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [1:0]       mode;
        logic [7:0]       ch;
        logic [4:0]       row;
        logic [6:0]       col;
        logic             fixed;
        tcw_pkg::result_t want;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  mode;
    logic [7:0]  char_code;
    logic [4:0]  read_row;
    logic [6:0]  read_col;
    logic        result_valid;
    logic        result_stall;
    logic [15:0] cell_value;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_line;
    logic        did_scroll;

    // Console model state.
    logic [15:0] screen_cells [CELLS];
    int          model_col;
    int          model_line;
    logic [7:0]  model_attr;

    tcw_pkg::result_t pending_results [$];
    directed_row_t    directed_rows [$];
    int               fault_count;
    logic             idle_on;

    text_console_writer_unit #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .char_code    (char_code),
        .read_row     (read_row),
        .read_col     (read_col),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cell_value   (cell_value),
        .cursor_column(cursor_column),
        .cursor_line  (cursor_line),
        .did_scroll   (did_scroll)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog for a hung run.
    initial
    begin
        #(LIMIT_TIME);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic tcw_pkg::result_t make_result(input logic [15:0] cell_word,
                                                     input int col, input int line,
                                                     input logic scrolled);
        tcw_pkg::result_t r;
        r.cell_value    = cell_word;
        r.cursor_column = 7'(col);
        r.cursor_line   = 5'(line);
        r.did_scroll    = scrolled;
        return r;
    endfunction

    // Console model: applies one item to the model state and returns its result.
    function automatic tcw_pkg::result_t console_model_step(input logic [1:0] m,
                                                            input logic [7:0] ch,
                                                            input logic [4:0] row,
                                                            input logic [6:0] col);
        logic [15:0] cell_word;
        logic        scrolled;
        cell_word = 16'h0000;
        scrolled  = 1'b0;
        case (m)
            tcw_pkg::MODE_PUT:
            begin
                if (ch == tcw_pkg::CH_NEWLINE)
                begin
                    model_col = 0;
                    model_line++;
                end
                else if (ch == tcw_pkg::CH_BACKSPACE)
                begin
                    if (model_col > 0)
                        model_col--;
                end
                else
                begin
                    screen_cells[model_line * COLUMNS + model_col] = {model_attr, ch};
                    model_col++;
                    if (model_col >= COLUMNS)
                    begin
                        model_col = 0;
                        model_line++;
                    end
                end
                // Running off the bottom shifts every row up and blanks the last one.
                if (model_line >= ROWS)
                begin
                    for (int i = 0; i < CELLS - COLUMNS; i++)
                        screen_cells[i] = screen_cells[i + COLUMNS];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++)
                        screen_cells[i] = tcw_pkg::BLANK_CELL;
                    model_line = ROWS - 1;
                    scrolled   = 1'b1;
                end
            end
            tcw_pkg::MODE_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_cells[i] = tcw_pkg::BLANK_CELL;
                model_col  = 0;
                model_line = 0;
            end
            tcw_pkg::MODE_READ:
            begin
                if (int'(row) < ROWS && int'(col) < COLUMNS)
                    cell_word = screen_cells[int'(row) * COLUMNS + int'(col)];
            end
            default:
            begin
            end
        endcase
        return make_result(cell_word, model_col, model_line, scrolled);
    endfunction

    task automatic add_item(input logic [1:0] m, input logic [7:0] ch, input logic [4:0] row,
                            input logic [6:0] col, input logic fixed,
                            input tcw_pkg::result_t want);
        directed_row_t r;
        r.kind  = ROW_ITEM;
        r.mode  = m;
        r.ch    = ch;
        r.row   = row;
        r.col   = col;
        r.fixed = fixed;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    task automatic add_cfg(input logic [7:0] value);
        directed_row_t r;
        r.kind  = ROW_CFG;
        r.mode  = tcw_pkg::MODE_PUT;
        r.ch    = value;
        r.row   = '0;
        r.col   = '0;
        r.fixed = 1'b0;
        r.want  = '0;
        directed_rows.push_back(r);
    endtask

    // Offers one item until it is accepted, then records its expected result.
    task automatic put_item(input logic [1:0] m, input logic [7:0] ch, input logic [4:0] row,
                            input logic [6:0] col, input logic fixed,
                            input tcw_pkg::result_t want);
        tcw_pkg::result_t predicted;
        @(negedge clk);
        item_valid = 1'b1;
        mode       = m;
        char_code  = ch;
        read_row   = row;
        read_col   = col;
        forever
        begin
            @(posedge clk);
            if (item_stall == 1'b0)
                break;
        end
        predicted = console_model_step(m, ch, row, col);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    // Holds the item channel idle for a number of cycles.
    task automatic sender_gap(input int cycles);
        @(negedge clk);
        item_valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Lowers valid and waits until every expected result has arrived.
    task automatic drain_results();
        @(negedge clk);
        item_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready == 1'b1)
                break;
        end
        model_attr = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic compare_result(input tcw_pkg::result_t got, input tcw_pkg::result_t want);
        if (got.cell_value !== want.cell_value)
        begin
            $error("cell_value: expected %h, actual %h", want.cell_value, got.cell_value);
            fault_count++;
        end
        if (got.cursor_column !== want.cursor_column)
        begin
            $error("cursor_column: expected %0d, actual %0d",
                   want.cursor_column, got.cursor_column);
            fault_count++;
        end
        if (got.cursor_line !== want.cursor_line)
        begin
            $error("cursor_line: expected %0d, actual %0d", want.cursor_line, got.cursor_line);
            fault_count++;
        end
        if (got.did_scroll !== want.did_scroll)
        begin
            $error("did_scroll: expected %0b, actual %0b", want.did_scroll, got.did_scroll);
            fault_count++;
        end
    endtask

    // Result side: checks each accepted result and drives stall in bursts.
    initial
    begin
        int               burst;
        int               hold;
        int               received;
        tcw_pkg::result_t got;
        burst        = 0;
        hold         = 0;
        received     = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall == 1'b0)
            begin
                got = make_result(cell_value, int'(cursor_column), int'(cursor_line),
                                  did_scroll);
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result item: cell_value %h", cell_value);
                    fault_count++;
                end
                else
                    compare_result(got, pending_results.pop_front());
                received++;
                // One long hold-off so the block backs up into its input.
                if (received == HOLD_AT)
                    hold = HOLD_CYCLES;
            end
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                result_stall = 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                result_stall = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                burst        = $urandom_range(1, 11) - 1;
                result_stall = 1'b1;
            end
            else
                result_stall = 1'b0;
        end
    end

    // Stimulus: reset, directed table, random phases, final report.
    initial
    begin
        int          pick;
        logic [1:0]  m;
        logic [7:0]  ch;
        logic [4:0]  row;
        logic [6:0]  col;
        logic [7:0]  attr;

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 8'h00;
        item_valid  = 1'b0;
        mode        = tcw_pkg::MODE_PUT;
        char_code   = 8'h00;
        read_row    = 5'd0;
        read_col    = 7'd0;
        idle_on     = 1'b0;
        fault_count = 0;
        for (int i = 0; i < CELLS; i++)
            screen_cells[i] = tcw_pkg::BLANK_CELL;
        model_col  = 0;
        model_line = 0;
        model_attr = tcw_pkg::ATTR_RESET;

        // Directed items; fixed rows carry their result inline.
        add_item(tcw_pkg::MODE_READ, 8'h00, 5'd0, 7'd0, 1'b1,
                 make_result(tcw_pkg::BLANK_CELL, 0, 0, 1'b0));
        add_item(tcw_pkg::MODE_READ, 8'hFF, 5'd24, 7'd79, 1'b1,
                 make_result(tcw_pkg::BLANK_CELL, 0, 0, 1'b0));
        add_item(tcw_pkg::MODE_READ, 8'h00, 5'd31, 7'd127, 1'b1,
                 make_result(16'h0000, 0, 0, 1'b0));
        add_item(tcw_pkg::MODE_READ, 8'h00, 5'd24, 7'd80, 1'b1,
                 make_result(16'h0000, 0, 0, 1'b0));
        add_item(tcw_pkg::MODE_READ, 8'h00, 5'd25, 7'd0, 1'b1,
                 make_result(16'h0000, 0, 0, 1'b0));
        add_item(MODE_UNUSED, 8'hFF, 5'd31, 7'd127, 1'b1, make_result(16'h0000, 0, 0, 1'b0));
        add_item(tcw_pkg::MODE_PUT, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0, 1'b1,
                 make_result(16'h0000, 0, 0, 1'b0));
        add_item(tcw_pkg::MODE_PUT, 8'h41, 5'd0, 7'd0, 1'b0, '0);
        add_item(tcw_pkg::MODE_PUT, 8'hFF, 5'd0, 7'd0, 1'b0, '0);
        add_item(tcw_pkg::MODE_PUT, 8'h00, 5'd0, 7'd0, 1'b0, '0);
        add_item(tcw_pkg::MODE_READ, 8'h00, 5'd0, 7'd0, 1'b1,
                 make_result(16'h0F41, 3, 0, 1'b0));
        add_item(tcw_pkg::MODE_PUT, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0, 1'b1,
                 make_result(16'h0000, 2, 0, 1'b0));
        add_item(MODE_UNUSED, 8'h00, 5'd0, 7'd0, 1'b1, make_result(16'h0000, 2, 0, 1'b0));
        add_item(tcw_pkg::MODE_PUT, tcw_pkg::CH_NEWLINE, 5'd0, 7'd0, 1'b1,
                 make_result(16'h0000, 0, 1, 1'b0));
        add_cfg(8'hA5);
        add_item(tcw_pkg::MODE_PUT, 8'h7E, 5'd0, 7'd0, 1'b0, '0);
        add_item(tcw_pkg::MODE_READ, 8'h00, 5'd1, 7'd0, 1'b1,
                 make_result(16'hA57E, 1, 1, 1'b0));
        add_cfg(8'h00);
        add_item(tcw_pkg::MODE_PUT, 8'h41, 5'd0, 7'd0, 1'b0, '0);
        add_cfg(8'hFF);
        add_item(tcw_pkg::MODE_PUT, 8'h42, 5'd0, 7'd0, 1'b0, '0);
        add_item(tcw_pkg::MODE_READ, 8'h00, 5'd1, 7'd1, 1'b0, '0);
        add_item(tcw_pkg::MODE_CLEAR, 8'h00, 5'd0, 7'd0, 1'b1,
                 make_result(16'h0000, 0, 0, 1'b0));
        add_item(tcw_pkg::MODE_READ, 8'h00, 5'd1, 7'd0, 1'b1,
                 make_result(tcw_pkg::BLANK_CELL, 0, 0, 1'b0));
        add_item(tcw_pkg::MODE_READ, 8'h00, 5'd0, 7'd2, 1'b0, '0);

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table; attribute writes wait for the block to drain.
        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_CFG)
            begin
                drain_results();
                write_attribute(directed_rows[k].ch);
            end
            else
                put_item(directed_rows[k].mode, directed_rows[k].ch, directed_rows[k].row,
                         directed_rows[k].col, directed_rows[k].fixed, directed_rows[k].want);
        end
        drain_results();

        // Random phases, each under its own attribute setting.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       attr = 8'h00;
                1:       attr = 8'hFF;
                PHASES - 1: attr = tcw_pkg::ATTR_RESET;
                default: attr = 8'($urandom_range(0, 255));
            endcase
            write_attribute(attr);
            idle_on = (p != 2 && p != PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (idle_on && $urandom_range(0, 3) == 0)
                    sender_gap($urandom_range(1, 11));
                ch  = 8'($urandom_range(0, 255));
                row = 5'($urandom_range(0, 31));
                col = 7'($urandom_range(0, 127));
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    // Mostly plain characters of any byte value, with line breaks and backspaces mixed in.
                    m = tcw_pkg::MODE_PUT;
                    pick = $urandom_range(0, 99);
                    if (pick < 8)
                        ch = tcw_pkg::CH_NEWLINE;
                    else if (pick < 14)
                        ch = tcw_pkg::CH_BACKSPACE;
                end
                else if (pick < 94)
                begin
                    // Reads are mostly on screen, often on the cursor row.
                    m = tcw_pkg::MODE_READ;
                    pick = $urandom_range(0, 3);
                    if (pick == 0)
                        row = 5'(model_line);
                    if (pick != 3)
                    begin
                        if (pick != 0)
                            row = 5'($urandom_range(0, ROWS - 1));
                        col = 7'($urandom_range(0, COLUMNS - 1));
                    end
                end
                else if (pick < 96)
                    m = tcw_pkg::MODE_CLEAR;
                else
                    m = MODE_UNUSED;
                put_item(m, ch, row, col, 1'b0, '0);
            end
            drain_results();
        end

        repeat (20) @(posedge clk);
        if (fault_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/tcw_pkg.sv
rtl/tcw_frame_mem.sv
rtl/tcw_sequencer.sv
rtl/text_console_writer_unit.sv
rtl/tcw_checker.sv
tb/sv/text_console_writer_unit_tb.sv
